[sv/imf_pkg.sv]
// shared types and constants of the image median filter
package imf_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE   = 4'd3;

    typedef struct packed {
        logic [7:0] sample_0;
        logic [7:0] sample_1;
        logic [7:0] sample_2;
        logic [7:0] sample_3;
    } t_pixel;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] median_0;
        logic [7:0] median_1;
        logic [7:0] median_2;
        logic [7:0] median_3;
        logic       last_of_run;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_FLUSH,
        S_SHIFT,
        S_OUT
    } t_state;

endpackage

[sv/image_median_filter.sv]
// image median filter: line store, window read sequencer and insertion sorters
// sequence: the accept cycle, then per result the states START, READ, FLUSH, SHIFT and OUT;
//   READ does one line store read a cycle for each of the n pixels of the clipped window (up to 49)
// throughput: one transaction at a time; a pixel that completes no window is taken without leaving IDLE
// reset: synchronous, clears position and restores register defaults; line store not cleared
module image_median_filter
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_HEIGHT   = 1024,
    parameter int MAX_WINDOW   = 7,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_pixel                 i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_result                o_out_data
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AW    = $clog2(MAX_WINDOW * MAX_WIDTH);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int NC    = MAX_WINDOW * MAX_WINDOW;
    localparam int NW    = $clog2(NC + 1);
    localparam int HMAX  = (MAX_WINDOW - 1) / 2;

    t_state r_state, n_state;

    logic [10:0] r_frame_width, r_frame_height;
    logic [2:0]  r_channel_count, r_window_size;

    logic [YW-1:0] r_row;
    logic [XW-1:0] r_col;
    logic [SW-1:0] r_slot;

    logic [YW-1:0] r_in_row, r_r, r_rhi, r_y, r_wy1;
    logic [SW-1:0] r_in_slot;
    logic [XW-1:0] r_c, r_clo, r_chi, r_x, r_wx0, r_wx1;
    logic [NW-1:0] r_shift;
    logic          r_rd_vld;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_rd_data;

    logic [7:0]    r_cell [MAX_CHANNELS][NC];
    logic          r_cell_vld [NC];

    // clamped configuration
    logic [XW-1:0] wl;
    logic [YW-1:0] hl;
    logic [2:0]    nch;
    logic [1:0]    hraw, h;

    always_comb begin
        if (r_frame_width == 11'd0) wl = '0;
        else if (32'(r_frame_width) > 32'(MAX_WIDTH)) wl = XW'(MAX_WIDTH - 1);
        else wl = XW'(r_frame_width - 11'd1);
        if (r_frame_height == 11'd0) hl = '0;
        else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) hl = YW'(MAX_HEIGHT - 1);
        else hl = YW'(r_frame_height - 11'd1);
        if (r_channel_count == 3'd0) nch = 3'd1;
        else if (32'(r_channel_count) > 32'(MAX_CHANNELS)) nch = 3'(MAX_CHANNELS);
        else nch = r_channel_count;
        hraw = r_window_size[2:1];
        h    = (32'(hraw) > 32'(HMAX)) ? 2'(HMAX) : hraw;
    end

    // position of the arriving pixel and its result range
    logic          accept;
    logic [YW-1:0] cur_r, rlo, rhi;
    logic [XW-1:0] cur_c, clo, chi;
    logic [SW-1:0] cur_slot;
    logic          any_r, any_c;

    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_row > hl || r_col > wl) begin
            cur_r    = '0;
            cur_c    = '0;
            cur_slot = '0;
        end else begin
            cur_r    = r_row;
            cur_c    = r_col;
            cur_slot = r_slot;
        end
        any_r = 1'b1;
        if (cur_r == hl) begin
            rlo = (cur_r >= YW'(h)) ? cur_r - YW'(h) : '0;
            rhi = cur_r;
        end else if (cur_r >= YW'(h)) begin
            rlo = cur_r - YW'(h);
            rhi = rlo;
        end else begin
            rlo   = '0;
            rhi   = '0;
            any_r = 1'b0;
        end
        any_c = 1'b1;
        if (cur_c == wl) begin
            clo = (cur_c >= XW'(h)) ? cur_c - XW'(h) : '0;
            chi = cur_c;
        end else if (cur_c >= XW'(h)) begin
            clo = cur_c - XW'(h);
            chi = clo;
        end else begin
            clo   = '0;
            chi   = '0;
            any_c = 1'b0;
        end
    end

    // window bounds of the current result
    logic [YW:0]   ysum;
    logic [XW:0]   xsum;
    logic [YW-1:0] wy0, wy1;
    logic [XW-1:0] wx0, wx1;
    logic [2:0]    ey, ex;
    logic [NW-1:0] wn;

    always_comb begin
        wy0  = (r_r >= YW'(h)) ? r_r - YW'(h) : '0;
        ysum = {1'b0, r_r} + (YW+1)'(h);
        wy1  = (ysum > {1'b0, hl}) ? hl : YW'(ysum);
        wx0  = (r_c >= XW'(h)) ? r_c - XW'(h) : '0;
        xsum = {1'b0, r_c} + (XW+1)'(h);
        wx1  = (xsum > {1'b0, wl}) ? wl : XW'(xsum);
        ey   = 3'(wy1 - wy0) + 3'd1;
        ex   = 3'(wx1 - wx0) + 3'd1;
        wn   = NW'(6'(ey) * 6'(ex));
    end

    // line store addressing; window rows sit at most 2h rows above the input row
    logic [SW-1:0] dd, rd_slot;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          rd_last;

    always_comb begin
        dd = SW'(r_in_row - r_y);
        if (r_in_slot >= dd) rd_slot = r_in_slot - dd;
        else rd_slot = SW'((SW+1)'(r_in_slot) + (SW+1)'(MAX_WINDOW) - (SW+1)'(dd));
        rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(r_x);
        wr_addr = AW'(cur_slot) * AW'(MAX_WIDTH) + AW'(cur_c);
        rd_last = (r_x == r_wx1) && (r_y == r_wy1);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            // channel k in byte k
            mem[wr_addr] <= {i_in_data.sample_3, i_in_data.sample_2,
                             i_in_data.sample_1, i_in_data.sample_0};
        end
        r_rd_data <= mem[rd_addr];
    end

    logic res_last;
    assign res_last = (r_r == r_rhi) && (r_c == r_chi);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && any_r && any_c) n_state = S_START;
            S_START: n_state = S_READ;
            S_READ:  if (rd_last) n_state = S_FLUSH;
            S_FLUSH: n_state = S_SHIFT;
            S_SHIFT: if (r_shift == '0) n_state = S_OUT;
            S_OUT:   if (!i_out_stall) n_state = res_last ? S_IDLE : S_START;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        logic [7:0] med [4];
        for (int k = 0; k < 4; k++) begin
            med[k] = 8'd0;
        end
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (3'(k) < nch) med[k] = r_cell[k][0];
        end
        o_in_stall              = (r_state != S_IDLE);
        o_out_valid             = (r_state == S_OUT);
        o_out_data.out_row      = 10'(r_r);
        o_out_data.out_col      = 10'(r_c);
        o_out_data.median_0     = med[0];
        o_out_data.median_1     = med[1];
        o_out_data.median_2     = med[2];
        o_out_data.median_3     = med[3];
        o_out_data.last_of_run  = res_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frame_width   <= 11'd1024;
            r_frame_height  <= 11'd1024;
            r_channel_count <= 3'd1;
            r_window_size   <= 3'd3;
            r_row           <= '0;
            r_col           <= '0;
            r_slot          <= '0;
            r_rd_vld        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_READ);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                    CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                    CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                    CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[2:0];
                    default: ;
                endcase
                if (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT ||
                    i_cfg_index == CFG_CHANNEL_COUNT || i_cfg_index == CFG_WINDOW_SIZE) begin
                    r_row  <= '0;
                    r_col  <= '0;
                    r_slot <= '0;
                end
            end else if (accept) begin
                if (cur_c == wl) begin
                    r_col <= '0;
                    if (cur_r == hl) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= cur_r + YW'(1);
                        r_slot <= (cur_slot == SW'(MAX_WINDOW - 1)) ? '0 : cur_slot + SW'(1);
                    end
                end else begin
                    r_row  <= cur_r;
                    r_slot <= cur_slot;
                    r_col  <= cur_c + XW'(1);
                end
            end
        end
    end

    // result sequencing and sorter cells
    always_ff @(posedge i_clk) begin
        logic [7:0] din;
        if (r_state == S_IDLE && accept) begin
            r_in_row  <= cur_r;
            r_in_slot <= cur_slot;
            r_r       <= rlo;
            r_c       <= clo;
            r_rhi     <= rhi;
            r_clo     <= clo;
            r_chi     <= chi;
        end
        if (r_state == S_START) begin
            r_y     <= wy0;
            r_wy1   <= wy1;
            r_x     <= wx0;
            r_wx0   <= wx0;
            r_wx1   <= wx1;
            r_shift <= wn >> 1;
        end
        if (r_state == S_READ) begin
            if (r_x == r_wx1) begin
                r_x <= r_wx0;
                if (r_y != r_wy1) r_y <= r_y + YW'(1);
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
        if (r_state == S_SHIFT && r_shift != '0) begin
            r_shift <= r_shift - NW'(1);
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                for (int i = 0; i < NC - 1; i++) begin
                    r_cell[k][i] <= r_cell[k][i+1];
                end
            end
        end
        if (r_state == S_OUT && !i_out_stall && !res_last) begin
            if (r_c == r_chi) begin
                r_c <= r_clo;
                r_r <= r_r + YW'(1);
            end else begin
                r_c <= r_c + XW'(1);
            end
        end
        // insertion keeps each row of cells sorted ascending
        if (r_rd_vld) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                din = r_rd_data[8*k +: 8];
                if (!(r_cell_vld[0] && r_cell[k][0] <= din)) begin
                    r_cell[k][0] <= din;
                end
                for (int i = 1; i < NC; i++) begin
                    if (r_cell_vld[i] && r_cell[k][i] <= din) begin
                        r_cell[k][i] <= r_cell[k][i];
                    end else if (r_cell_vld[i-1] && r_cell[k][i-1] > din) begin
                        r_cell[k][i] <= r_cell[k][i-1];
                    end else begin
                        r_cell[k][i] <= din;
                    end
                end
            end
            r_cell_vld[0] <= 1'b1;
            for (int i = 1; i < NC; i++) begin
                r_cell_vld[i] <= r_cell_vld[i] || r_cell_vld[i-1];
            end
        end
        if (r_state == S_START) begin
            for (int i = 0; i < NC; i++) begin
                r_cell_vld[i] <= 1'b0;
            end
        end
    end

endmodule
